// ===== rtl/core/lnc_pkg.sv =====
// lnc_pkg: shared types, opcodes, register indexes and the divider reload
// function of the LFSR noise channel. No dependencies.
package lnc_pkg;

	localparam int LENGTH_FULL_DEF = 64;

	localparam logic [2:0] OP_CLOCK    = 3'd0;
	localparam logic [2:0] OP_LENGTH   = 3'd1;
	localparam logic [2:0] OP_ENVELOPE = 3'd2;
	localparam logic [2:0] OP_READ     = 3'd3;
	localparam logic [2:0] OP_WRITE    = 3'd4;
	localparam logic [2:0] OP_POWER    = 3'd5;

	localparam logic [1:0] REG_LENGTH   = 2'd0;
	localparam logic [1:0] REG_ENVELOPE = 2'd1;
	localparam logic [1:0] REG_POLY     = 2'd2;
	localparam logic [1:0] REG_TRIGGER  = 2'd3;

	localparam logic [7:0]  READ_IDLE  = 8'hFF;
	localparam logic [7:0]  TRIG_READ  = 8'hBF;
	localparam logic [14:0] LFSR_SEED  = 15'h7FFF;
	localparam logic [3:0]  VOL_MAX    = 4'hF;
	localparam logic [19:0] DIV_SAT    = 20'hFFFFF;

	typedef struct packed {
		logic [2:0] op;
		logic [1:0] reg_index;
		logic [7:0] write_byte;
		logic [7:0] cycle_count;
	} item_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic [3:0] sample;
		logic       active;
	} result_t;

	// (code == 0 ? 8 : 16 * code) << shift, saturated to 20 bits
	function automatic logic [19:0] reload_value(input logic [2:0] code,
		input logic [3:0] shift);
		logic [23:0] base;
		logic [23:0] v;
		base = (code == 3'd0) ? 24'd8 : {17'd0, code, 4'd0};
		v = base << shift;
		return (v > {4'd0, DIV_SAT}) ? DIV_SAT : v[19:0];
	endfunction

endpackage

// ===== rtl/core/lfsr_noise_channel.sv =====
// LFSR noise channel, top level.
// Requests (req, req_valid/req_ready) carry one event each: clock tick of
// cycle_count cycles, length tick, envelope tick, register read, register
// write or power switch. Each request yields exactly one response (rsp,
// rsp_valid/rsp_ready) with read data, held sample and channel enable.
// A transaction is accepted on a rising edge with valid and ready high.
// An accepted request is captured in the input register and is applied to the
// channel state at the edge at which it advances; its response is valid from then on.
// Throughput: one transaction per cycle while responses are taken, as the input
// register feeds the state and response registers through combinational update logic.
// When the receiver stalls, the response register holds; one further request
// waits in the input register, and req_ready drops until the response is taken.
// Reset (arst_n low) clears the input and response valid flags and every
// channel register to zero; no clearing pass is needed.
// Depends on lnc_pkg and lnc_core.
module lfsr_noise_channel #(
	parameter int LENGTH_FULL = lnc_pkg::LENGTH_FULL_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  lnc_pkg::item_t   req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output lnc_pkg::result_t rsp
);
	import lnc_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t rsp_q;
	logic    rsp_valid_q;
	result_t core_result;
	logic    advance;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
	end

	lnc_core #(
		.LENGTH_FULL(LENGTH_FULL)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (advance),
		.item  (item_s1),
		.result(core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= core_result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/core/lnc_core.sv =====
// lnc_core: channel state registers and the single-pass update logic.
// One transaction is applied per fire strobe; the result reflects the new state.
// Depends on lnc_pkg.
module lnc_core #(
	parameter int LENGTH_FULL = lnc_pkg::LENGTH_FULL_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  lnc_pkg::item_t   item,
	output lnc_pkg::result_t result
);
	import lnc_pkg::*;

	localparam int         LEN_W    = $clog2(LENGTH_FULL + 1);
	localparam logic [7:0] LEN_MASK = 8'((LENGTH_FULL - 1) & 255);
	localparam logic [LEN_W-1:0] LEN_FULL_V = LEN_W'(LENGTH_FULL);

	logic [LEN_W-1:0] length_left_q, length_left_d;
	logic        chan_enabled_q, chan_enabled_d;
	logic [2:0]  env_period_q, env_period_d;
	logic        env_up_q, env_up_d;
	logic [3:0]  env_start_q, env_start_d;
	logic [2:0]  div_code_q, div_code_d;
	logic        narrow_q, narrow_d;
	logic [3:0]  clock_shift_q, clock_shift_d;
	logic        length_on_q, length_on_d;
	logic [19:0] divider_q, divider_d;
	logic [14:0] noise_q, noise_d;
	logic [2:0]  env_count_q, env_count_d;
	logic [3:0]  volume_q, volume_d;
	logic [3:0]  held_q, held_d;
	logic [7:0]  read_byte;

	logic        frozen;
	logic        fb;
	logic [7:0]  wb;

	assign frozen = (clock_shift_q[3:1] == 3'b111);
	assign fb     = noise_q[0] ^ noise_q[1];
	assign wb     = item.write_byte;

	always_comb begin
		length_left_d  = length_left_q;
		chan_enabled_d = chan_enabled_q;
		env_period_d   = env_period_q;
		env_up_d       = env_up_q;
		env_start_d    = env_start_q;
		div_code_d     = div_code_q;
		narrow_d       = narrow_q;
		clock_shift_d  = clock_shift_q;
		length_on_d    = length_on_q;
		divider_d      = divider_q;
		noise_d        = noise_q;
		env_count_d    = env_count_q;
		volume_d       = volume_q;
		held_d         = held_q;
		read_byte      = READ_IDLE;

		unique case (item.op)
			OP_CLOCK: begin
				if (!frozen) begin
					held_d = (chan_enabled_q && !noise_q[0]) ? volume_q : 4'd0;
					if ({12'd0, item.cycle_count} < divider_q) begin
						divider_d = divider_q - {12'd0, item.cycle_count};
					end else begin
						divider_d = reload_value(div_code_q, clock_shift_q);
						noise_d   = {fb, noise_q[14:1]};
						if (narrow_q) begin
							noise_d[6] = fb;
						end
					end
				end
			end
			OP_LENGTH: begin
				if (length_on_q && length_left_q != '0) begin
					length_left_d = length_left_q - LEN_W'(1);
					if (length_left_q == LEN_W'(1)) begin
						chan_enabled_d = 1'b0;
					end
				end
			end
			OP_ENVELOPE: begin
				if (env_count_q != 3'd0) begin
					env_count_d = env_count_q - 3'd1;
					if (env_count_q == 3'd1) begin
						if (env_up_q && volume_q < VOL_MAX) begin
							volume_d = volume_q + 4'd1;
						end else if (!env_up_q && volume_q != 4'd0) begin
							volume_d = volume_q - 4'd1;
						end
						env_count_d = env_period_q;
					end
				end
			end
			OP_READ: begin
				unique case (item.reg_index)
					REG_ENVELOPE: read_byte = {env_start_q, env_up_q, env_period_q};
					REG_POLY:     read_byte = {clock_shift_q, narrow_q, div_code_q};
					REG_TRIGGER:  read_byte = TRIG_READ | {1'b0, length_on_q, 6'd0};
					REG_LENGTH:   read_byte = READ_IDLE;
				endcase
			end
			OP_WRITE: begin
				unique case (item.reg_index)
					REG_LENGTH: begin
						length_left_d = LEN_FULL_V - LEN_W'(wb & LEN_MASK);
					end
					REG_ENVELOPE: begin
						env_period_d = wb[2:0];
						env_up_d     = wb[3];
						env_start_d  = wb[7:4];
						if (wb[7:3] == 5'd0) begin
							chan_enabled_d = 1'b0;
						end
					end
					REG_POLY: begin
						div_code_d    = wb[2:0];
						narrow_d      = wb[3];
						clock_shift_d = wb[7:4];
					end
					REG_TRIGGER: begin
						length_on_d = wb[6];
						if (wb[7]) begin
							chan_enabled_d = env_up_q || (env_start_q != 4'd0);
							if (length_left_q == '0) begin
								length_left_d = LEN_FULL_V;
								length_on_d   = 1'b0;
							end
							divider_d   = reload_value(div_code_q, clock_shift_q);
							noise_d     = LFSR_SEED;
							env_count_d = env_period_q;
							volume_d    = env_start_q;
						end
					end
				endcase
			end
			OP_POWER: begin
				if (!wb[0]) begin
					env_period_d  = 3'd0;
					env_up_d      = 1'b0;
					env_start_d   = 4'd0;
					div_code_d    = 3'd0;
					narrow_d      = 1'b0;
					clock_shift_d = 4'd0;
					length_on_d   = 1'b0;
					divider_d     = 20'd0;
					noise_d       = 15'd0;
					env_count_d   = 3'd0;
					volume_d      = 4'd0;
					held_d        = 4'd0;
				end
				chan_enabled_d = wb[0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_left_q  <= '0;
			chan_enabled_q <= 1'b0;
			env_period_q   <= 3'd0;
			env_up_q       <= 1'b0;
			env_start_q    <= 4'd0;
			div_code_q     <= 3'd0;
			narrow_q       <= 1'b0;
			clock_shift_q  <= 4'd0;
			length_on_q    <= 1'b0;
			divider_q      <= 20'd0;
			noise_q        <= 15'd0;
			env_count_q    <= 3'd0;
			volume_q       <= 4'd0;
			held_q         <= 4'd0;
		end else if (fire) begin
			length_left_q  <= length_left_d;
			chan_enabled_q <= chan_enabled_d;
			env_period_q   <= env_period_d;
			env_up_q       <= env_up_d;
			env_start_q    <= env_start_d;
			div_code_q     <= div_code_d;
			narrow_q       <= narrow_d;
			clock_shift_q  <= clock_shift_d;
			length_on_q    <= length_on_d;
			divider_q      <= divider_d;
			noise_q        <= noise_d;
			env_count_q    <= env_count_d;
			volume_q       <= volume_d;
			held_q         <= held_d;
		end
	end

	assign result.read_byte = read_byte;
	assign result.sample    = held_d;
	assign result.active    = chan_enabled_d;

	a_power_off_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.op == OP_POWER && !item.write_byte[0]
		|=> !chan_enabled_q && noise_q == 15'd0 && divider_q == 20'd0 && held_q == 4'd0)
		else $error("power off did not clear channel state");

	a_length_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(length_left_q) <= LENGTH_FULL)
		else $error("length counter above full length");

	a_frozen_clock: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.op == OP_CLOCK && frozen
		|=> $stable(divider_q) && $stable(noise_q) && $stable(held_q))
		else $error("frozen clock tick changed divider or LFSR");

	a_read_no_side_effect: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.op == OP_READ
		|=> $stable(length_left_q) && $stable(chan_enabled_q) && $stable(volume_q))
		else $error("register read changed channel state");

endmodule
